// ----- rtl/core/sfr_pkg.sv -----
`default_nettype none
package sfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ROLE_W    = 2;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
  localparam logic [BYTE_W-1:0] THRESHOLD_RESET    = 8'h00;

  localparam logic REG_START_MARKER = 1'b0;
  localparam logic REG_THRESHOLD    = 1'b1;

  localparam logic [ROLE_W-1:0] ROLE_FUNC = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_LEN  = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_DATA = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] function_threshold;
  } cfg_t;

endpackage
`default_nettype wire

// ----- rtl/core/sfr_channels.sv -----
`default_nettype none
interface sfr_rx_if;
  logic                        valid;
  logic                        ready;
  logic [sfr_pkg::BYTE_W-1:0]  rx_byte;
  logic                        line_error;

  modport source (output valid, output rx_byte, output line_error, input ready);
  modport sink   (input valid, input rx_byte, input line_error, output ready);
endinterface

interface sfr_result_if;
  logic                        valid;
  logic                        ready;
  logic [sfr_pkg::BYTE_W-1:0]  data_byte;
  logic [sfr_pkg::ROLE_W-1:0]  byte_role;
  logic                        frame_end;
  logic                        frame_abort;

  modport source (output valid, output data_byte, output byte_role, output frame_end,
                  output frame_abort, input ready);
  modport sink   (input valid, input data_byte, input byte_role, input frame_end,
                  input frame_abort, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/sfr_cfg_regs.sv -----
`default_nettype none
module sfr_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sfr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [sfr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [sfr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output sfr_pkg::cfg_t                         cfg
);
  import sfr_pkg::*;

  logic       wr_en;
  logic       reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker       <= START_MARKER_RESET;
      cfg.function_threshold <= THRESHOLD_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_START_MARKER: cfg.start_marker       <= pwdata[BYTE_W-1:0];
        REG_THRESHOLD:    cfg.function_threshold <= pwdata[BYTE_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_START_MARKER: prdata[BYTE_W-1:0] = cfg.start_marker;
      REG_THRESHOLD:    prdata[BYTE_W-1:0] = cfg.function_threshold;
      default:          prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/serial_frame_receiver_top.sv -----
// Serial frame receiver: one received byte taken per cycle, back to back, while the result channel is not stalled.
// A result is registered and appears on the result channel in the cycle after its byte is accepted.
// Throughput: one byte per cycle; a single-stage output register is the only
// buffer, so a stalled result holds input ready low until it is taken.
// Synchronous active-high reset: idle phase, no result pending, registers at defaults.
`default_nettype none
module serial_frame_receiver_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  sfr_rx_if.sink                                rx,
  sfr_result_if.source                          result,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sfr_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [sfr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [sfr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import sfr_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FUNC,
    PH_LEN,
    PH_DATA
  } phase_t;

  cfg_t              cfg;
  phase_t            phase, phase_next;
  logic [BYTE_W-1:0] function_code, function_code_next;
  logic [BYTE_W-1:0] expected_length, expected_length_next;
  logic [BYTE_W-1:0] payload_count, payload_count_next;
  logic [BYTE_W-1:0] count_inc;

  logic              accept;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic [ROLE_W-1:0] emit_role;
  logic              emit_end;
  logic              emit_abort;

  sfr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign rx.ready  = !result.valid || result.ready;
  assign accept    = rx.valid && rx.ready;
  assign count_inc = payload_count + BYTE_W'(1);

  always_comb begin
    phase_next           = phase;
    function_code_next   = function_code;
    expected_length_next = expected_length;
    payload_count_next   = payload_count;
    emit                 = 1'b0;
    emit_byte            = rx.rx_byte;
    emit_role            = ROLE_DATA;
    emit_end             = 1'b0;
    emit_abort           = 1'b0;
    if (rx.line_error) begin
      phase_next           = PH_IDLE;
      expected_length_next = '0;
      payload_count_next   = '0;
      if (phase != PH_IDLE) begin
        emit       = 1'b1;
        emit_byte  = '0;
        emit_role  = ROLE_FUNC;
        emit_abort = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_FUNC: begin
          function_code_next = rx.rx_byte;
          phase_next         = PH_LEN;
          emit               = 1'b1;
          emit_role          = ROLE_FUNC;
        end
        PH_LEN: begin
          emit = 1'b1;
          if (function_code > cfg.function_threshold) begin
            emit_role            = ROLE_LEN;
            expected_length_next = rx.rx_byte;
            payload_count_next   = '0;
            if (rx.rx_byte == '0) begin
              phase_next           = PH_IDLE;
              expected_length_next = '0;
              emit_end             = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end else begin
            phase_next           = PH_IDLE;
            expected_length_next = '0;
            payload_count_next   = '0;
            emit_end             = 1'b1;
          end
        end
        PH_DATA: begin
          emit               = 1'b1;
          payload_count_next = count_inc;
          if (count_inc >= expected_length) begin
            phase_next           = PH_IDLE;
            expected_length_next = '0;
            payload_count_next   = '0;
            emit_end             = 1'b1;
          end
        end
        PH_IDLE: begin
          if (rx.rx_byte == cfg.start_marker) begin
            phase_next           = PH_FUNC;
            expected_length_next = '0;
            payload_count_next   = '0;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      function_code   <= '0;
      expected_length <= '0;
      payload_count   <= '0;
      result.valid    <= 1'b0;
    end else begin
      if (accept) begin
        phase           <= phase_next;
        function_code   <= function_code_next;
        expected_length <= expected_length_next;
        payload_count   <= payload_count_next;
      end
      if (accept && emit) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result.data_byte   <= emit_byte;
      result.byte_role   <= emit_role;
      result.frame_end   <= emit_end;
      result.frame_abort <= emit_abort;
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_serial_frame_receiver_top.sv -----
`timescale 1ns / 100ps
module tb_serial_frame_receiver_top;
  import sfr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned PHASE_ITEMS  = 225;
  localparam logic [APB_ADDR_W-1:0] ADDR_MARKER    = {REG_START_MARKER, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};

  typedef enum logic [2:0] {
    SEEK_MARKER,
    GET_FUNC,
    GET_LEN_ARG,
    GET_PAYLOAD
  } parse_phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [ROLE_W-1:0] byte_role;
    logic              frame_end;
    logic              frame_abort;
  } frame_out_t;

  class frame_scoreboard;
    parse_phase_t      phase;
    logic [BYTE_W-1:0] func_code;
    logic [BYTE_W-1:0] length;
    logic [BYTE_W-1:0] payload_seen;
    logic [BYTE_W-1:0] marker;
    logic [BYTE_W-1:0] threshold;
    frame_out_t        expected_q[$];
    int                errors;

    function new();
      phase        = SEEK_MARKER;
      func_code    = '0;
      length       = '0;
      payload_seen = '0;
      marker       = START_MARKER_RESET;
      threshold    = THRESHOLD_RESET;
      errors       = 0;
    endfunction

    task report(input string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    function void write_register(input logic idx, input logic [BYTE_W-1:0] value);
      case (idx)
        REG_START_MARKER: marker = value;
        REG_THRESHOLD:    threshold = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void close_frame();
      phase        = SEEK_MARKER;
      payload_seen = '0;
      length       = '0;
    endfunction

    function void push(input logic [BYTE_W-1:0] b, input logic [ROLE_W-1:0] role,
                       input logic fin, input logic abrt);
      frame_out_t r;
      r = '{data_byte: b, byte_role: role, frame_end: fin, frame_abort: abrt};
      expected_q.push_back(r);
    endfunction

    // Returns 1 when the byte takes part in a frame rather than being ignored.
    function bit note_rx_byte(input logic [BYTE_W-1:0] b, input logic err);
      bit open;
      bit engaged;
      open    = (phase != SEEK_MARKER);
      engaged = open || (!err && b == marker);
      if (err) begin
        if (open) push('0, ROLE_FUNC, 1'b0, 1'b1);
        close_frame();
        return engaged;
      end
      case (phase)
        GET_FUNC: begin
          func_code = b;
          phase     = GET_LEN_ARG;
          push(b, ROLE_FUNC, 1'b0, 1'b0);
        end
        GET_LEN_ARG: begin
          if (func_code > threshold) begin
            length       = b;
            payload_seen = '0;
            if (b == '0) begin
              close_frame();
              push(b, ROLE_LEN, 1'b1, 1'b0);
            end else begin
              phase = GET_PAYLOAD;
              push(b, ROLE_LEN, 1'b0, 1'b0);
            end
          end else begin
            close_frame();
            push(b, ROLE_DATA, 1'b1, 1'b0);
          end
        end
        GET_PAYLOAD: begin
          payload_seen = payload_seen + 1'b1;
          if (payload_seen >= length) begin
            close_frame();
            push(b, ROLE_DATA, 1'b1, 1'b0);
          end else begin
            push(b, ROLE_DATA, 1'b0, 1'b0);
          end
        end
        default: begin
          phase = SEEK_MARKER;
          if (b == marker) begin
            phase        = GET_FUNC;
            payload_seen = '0;
            length       = '0;
          end
        end
      endcase
      return engaged;
    endfunction

    task check_result(input frame_out_t got);
      frame_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h role %0d end %0b abort %0b",
                         got.data_byte, got.byte_role, got.frame_end, got.frame_abort));
      end else begin
        want = expected_q.pop_front();
        if (got.data_byte !== want.data_byte)
          report($sformatf("data_byte got %02h want %02h", got.data_byte, want.data_byte));
        if (got.byte_role !== want.byte_role)
          report($sformatf("byte_role got %0d want %0d", got.byte_role, want.byte_role));
        if (got.frame_end !== want.frame_end)
          report($sformatf("frame_end got %0b want %0b", got.frame_end, want.frame_end));
        if (got.frame_abort !== want.frame_abort)
          report($sformatf("frame_abort got %0b want %0b", got.frame_abort, want.frame_abort));
      end
    endtask

    task close_out();
      if (expected_q.size() != 0)
        report($sformatf("%0d expected results never arrived", expected_q.size()));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  calm;
  int                    frame_items;

  frame_scoreboard sb = new();

  sfr_rx_if     rx_ch();
  sfr_result_if frame_ch();

  serial_frame_receiver_top u_top (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_ch),
    .result  (frame_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Alternate between stretches with random gaps and stalls and stretches with no gaps on either side.
  initial begin
    calm = 1'b0;
    forever begin
      calm = 1'b0;
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm = 1'b1;
      repeat ($urandom_range(30, 120)) @(posedge clk);
    end
  end

  initial begin
    int stall;
    stall = 0;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && frame_ch.valid && frame_ch.ready)
        sb.check_result('{data_byte: frame_ch.data_byte, byte_role: frame_ch.byte_role,
                          frame_end: frame_ch.frame_end, frame_abort: frame_ch.frame_abort});
      if (!rst && stall == 0 && !calm && $urandom_range(0, 3) == 0)
        stall = pick_gap() + 1;
      frame_ch.ready <= !rst && (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    sb.report("run exceeded cycle limit");
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic err);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid      <= 1'b1;
    rx_ch.rx_byte    <= b;
    rx_ch.line_error <= err;
    do @(posedge clk); while (!rx_ch.ready);
    frame_items += sb.note_rx_byte(b, err);
  endtask

  task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [BYTE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {{(APB_DATA_W-BYTE_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    rx_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [BYTE_W-1:0] marker, input logic [BYTE_W-1:0] thr);
    apb_write(ADDR_MARKER, marker);
    sb.write_register(REG_START_MARKER, marker);
    apb_write(ADDR_THRESHOLD, thr);
    sb.write_register(REG_THRESHOLD, thr);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_item(8'($urandom), $urandom_range(0, 3) == 0);
  endtask

  task automatic send_frame();
    logic [BYTE_W-1:0] fc;
    logic [BYTE_W-1:0] seq[$];
    logic              err;
    int                r;
    int                n;
    int                stop;
    seq.push_back(sb.marker);
    r = $urandom_range(0, 9);
    if (r < 4 || sb.threshold == 8'hFF) fc = 8'($urandom);
    else if (r < 7) fc = 8'($urandom_range(255, sb.threshold + 1));
    else fc = 8'($urandom_range(sb.threshold, 0));
    seq.push_back(fc);
    if (fc > sb.threshold) begin
      r = $urandom_range(0, 99);
      if (r < 75) n = $urandom_range(0, 6);
      else if (r < 98) n = $urandom_range(7, 24);
      else n = 255;
      seq.push_back(n[7:0]);
      repeat (n) seq.push_back(($urandom_range(0, 7) == 0) ? sb.marker : 8'($urandom));
    end else begin
      seq.push_back(8'($urandom));
    end
    // Truncate now and then so the next marker lands inside an open frame.
    stop = seq.size();
    if ($urandom_range(0, 19) == 0) stop = $urandom_range(1, seq.size() - 1);
    for (int i = 0; i < stop; i++) begin
      err = (i > 0) && ($urandom_range(0, 39) == 0);
      send_item(seq[i], err);
      if (err) break;
    end
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] marker, input logic [BYTE_W-1:0] thr);
    drain();
    set_config(marker, thr);
    frame_items = 0;
    while (frame_items < PHASE_ITEMS) begin
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_frame();
    end
  endtask

  initial begin
    rst              <= 1'b1;
    rx_ch.valid      <= 1'b0;
    rx_ch.rx_byte    <= '0;
    rx_ch.line_error <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    frame_items      = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle bytes, including a marker value carrying a line error
    send_item(8'h00, 1'b0);
    send_item(START_MARKER_RESET, 1'b1);
    // short frame with argument
    send_item(START_MARKER_RESET, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    // zero length ends at the length byte
    send_item(START_MARKER_RESET, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    // payload holding the marker value
    send_item(START_MARKER_RESET, 1'b0);
    send_item(8'h01, 1'b0);
    send_item(8'h02, 1'b0);
    send_item(START_MARKER_RESET, 1'b0);
    send_item(8'h55, 1'b0);
    // abort in every open phase
    send_item(START_MARKER_RESET, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(START_MARKER_RESET, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(START_MARKER_RESET, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h03, 1'b0);
    send_item(8'h12, 1'b0);
    send_item(8'h7F, 1'b1);

    run_phase(8'h7E, 8'h80);
    run_phase(8'h00, 8'hFF);
    run_phase(8'hFF, 8'h00);
    run_phase(8'($urandom), 8'($urandom));
    run_phase(START_MARKER_RESET, 8'h3F);
    run_phase(8'($urandom), 8'($urandom));

    drain();
    sb.close_out();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
